/* src/alist_pkg.sv */
package alist_pkg;

	// default list depth
	localparam int CAPACITY_DEF = 16;

	// fixed field widths
	localparam int KEY_W  = 32;
	localparam int PAY_W  = 64;
	localparam int KIND_W = 3;

	// microprogram step counter width
	localparam int STEP_W = 5;

	// request kinds
	localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
	localparam logic [KIND_W-1:0] KIND_APPEND = 3'd1;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd2;
	localparam logic [KIND_W-1:0] KIND_MODIFY = 3'd3;
	localparam logic [KIND_W-1:0] KIND_SEARCH = 3'd4;

	// result status codes
	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_BADPOS   = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	// next step selection
	typedef enum logic [1:0] {
		NXT_SEQ      = 2'd0,
		NXT_JUMP     = 2'd1,
		NXT_DISPATCH = 2'd2,
		NXT_DONE     = 2'd3
	} nxt_t;

	// jump conditions
	typedef enum logic [3:0] {
		C_ALWAYS     = 4'd0,
		C_FULL       = 4'd1,
		C_EMPTY      = 4'd2,
		C_POS_GT_CNT = 4'd3,
		C_POS_GE_CNT = 4'd4,
		C_PTR_EQ_POS = 4'd5,
		C_PTR_LAST   = 4'd6,
		C_PTR_EQ_CNT = 4'd7,
		C_KEY_MATCH  = 4'd8
	} cond_t;

	// entry pointer operations
	typedef enum logic [2:0] {
		PTR_HOLD     = 3'd0,
		PTR_LOAD_CNT = 3'd1,
		PTR_LOAD_POS = 3'd2,
		PTR_ZERO     = 3'd3,
		PTR_INC      = 3'd4,
		PTR_DEC      = 3'd5
	} ptr_op_t;

	// read address selection
	typedef enum logic [1:0] {
		RD_PTR      = 2'd0,
		RD_PTR_DOWN = 2'd1,
		RD_PTR_UP   = 2'd2
	} rd_sel_t;

	// write source, always written at the pointer
	typedef enum logic [1:0] {
		WR_NONE  = 2'd0,
		WR_SHIFT = 2'd1,
		WR_REQ   = 2'd2
	} wr_op_t;

	// entry count operations
	typedef enum logic [1:0] {
		CNT_HOLD = 2'd0,
		CNT_INC  = 2'd1,
		CNT_DEC  = 2'd2
	} cnt_op_t;

	// one control word of the microprogram
	typedef struct packed {
		nxt_t              nxt;
		cond_t             cond;
		logic [STEP_W-1:0] target;
		ptr_op_t           ptr_op;
		rd_sel_t           rd_sel;
		wr_op_t            wr_op;
		cnt_op_t           cnt_op;
		logic              capture;
		status_t           status;
	} ctl_word_t;

	// datapath conditions seen by the sequencer
	typedef struct packed {
		logic full;
		logic empty;
		logic pos_gt_cnt;
		logic pos_ge_cnt;
		logic ptr_eq_pos;
		logic ptr_last;
		logic ptr_eq_cnt;
		logic key_match;
	} flags_t;

	// microprogram addresses
	localparam logic [STEP_W-1:0] STEP_DISPATCH = 5'd0;
	localparam logic [STEP_W-1:0] STEP_INS      = 5'd1;
	localparam logic [STEP_W-1:0] STEP_INS_LOOP = 5'd3;
	localparam logic [STEP_W-1:0] STEP_INS_PUT  = 5'd6;
	localparam logic [STEP_W-1:0] STEP_APP      = 5'd7;
	localparam logic [STEP_W-1:0] STEP_REM      = 5'd9;
	localparam logic [STEP_W-1:0] STEP_REM_LOOP = 5'd11;
	localparam logic [STEP_W-1:0] STEP_REM_END  = 5'd14;
	localparam logic [STEP_W-1:0] STEP_MOD      = 5'd15;
	localparam logic [STEP_W-1:0] STEP_SRC      = 5'd18;
	localparam logic [STEP_W-1:0] STEP_SRC_LOOP = 5'd19;
	localparam logic [STEP_W-1:0] STEP_SRC_HIT  = 5'd22;
	localparam logic [STEP_W-1:0] STEP_MISS     = 5'd23;
	localparam logic [STEP_W-1:0] STEP_FULL     = 5'd24;
	localparam logic [STEP_W-1:0] STEP_EMPTY    = 5'd25;
	localparam logic [STEP_W-1:0] STEP_BADPOS   = 5'd26;
	localparam logic [STEP_W-1:0] STEP_UNKNOWN  = 5'd27;

	// builds one control word
	function automatic ctl_word_t uop(
		input nxt_t              nxt,
		input cond_t             cond,
		input logic [STEP_W-1:0] target,
		input ptr_op_t           ptr_op,
		input rd_sel_t           rd_sel,
		input wr_op_t            wr_op,
		input cnt_op_t           cnt_op,
		input logic              capture,
		input status_t           status
	);
		ctl_word_t cw;
		cw.nxt     = nxt;
		cw.cond    = cond;
		cw.target  = target;
		cw.ptr_op  = ptr_op;
		cw.rd_sel  = rd_sel;
		cw.wr_op   = wr_op;
		cw.cnt_op  = cnt_op;
		cw.capture = capture;
		cw.status  = status;
		return cw;
	endfunction

	// microprogram rom
	function automatic ctl_word_t microcode(input logic [STEP_W-1:0] step);
		ctl_word_t cw;
		unique case (step)
			// decode the request kind
			5'd0:  cw = uop(NXT_DISPATCH, C_ALWAYS, STEP_DISPATCH, PTR_HOLD, RD_PTR,
				WR_NONE, CNT_HOLD, 1'b0, ST_OK);
			// insert: full check, position check, then shift up from the end
			5'd1:  cw = uop(NXT_JUMP, C_FULL, STEP_FULL, PTR_HOLD, RD_PTR,
				WR_NONE, CNT_HOLD, 1'b0, ST_OK);
			5'd2:  cw = uop(NXT_JUMP, C_POS_GT_CNT, STEP_BADPOS, PTR_LOAD_CNT, RD_PTR,
				WR_NONE, CNT_HOLD, 1'b0, ST_OK);
			5'd3:  cw = uop(NXT_JUMP, C_PTR_EQ_POS, STEP_INS_PUT, PTR_HOLD, RD_PTR_DOWN,
				WR_NONE, CNT_HOLD, 1'b0, ST_OK);
			5'd4:  cw = uop(NXT_SEQ, C_ALWAYS, STEP_DISPATCH, PTR_DEC, RD_PTR,
				WR_SHIFT, CNT_HOLD, 1'b0, ST_OK);
			5'd5:  cw = uop(NXT_JUMP, C_ALWAYS, STEP_INS_LOOP, PTR_HOLD, RD_PTR,
				WR_NONE, CNT_HOLD, 1'b0, ST_OK);
			5'd6:  cw = uop(NXT_DONE, C_ALWAYS, STEP_DISPATCH, PTR_HOLD, RD_PTR,
				WR_REQ, CNT_INC, 1'b0, ST_OK);
			// append at the end
			5'd7:  cw = uop(NXT_JUMP, C_FULL, STEP_FULL, PTR_LOAD_CNT, RD_PTR,
				WR_NONE, CNT_HOLD, 1'b0, ST_OK);
			5'd8:  cw = uop(NXT_DONE, C_ALWAYS, STEP_DISPATCH, PTR_HOLD, RD_PTR,
				WR_REQ, CNT_INC, 1'b0, ST_OK);
			// remove: shift down from the position
			5'd9:  cw = uop(NXT_JUMP, C_EMPTY, STEP_EMPTY, PTR_HOLD, RD_PTR,
				WR_NONE, CNT_HOLD, 1'b0, ST_OK);
			5'd10: cw = uop(NXT_JUMP, C_POS_GE_CNT, STEP_BADPOS, PTR_LOAD_POS, RD_PTR,
				WR_NONE, CNT_HOLD, 1'b0, ST_OK);
			5'd11: cw = uop(NXT_JUMP, C_PTR_LAST, STEP_REM_END, PTR_HOLD, RD_PTR_UP,
				WR_NONE, CNT_HOLD, 1'b0, ST_OK);
			5'd12: cw = uop(NXT_SEQ, C_ALWAYS, STEP_DISPATCH, PTR_INC, RD_PTR,
				WR_SHIFT, CNT_HOLD, 1'b0, ST_OK);
			5'd13: cw = uop(NXT_JUMP, C_ALWAYS, STEP_REM_LOOP, PTR_HOLD, RD_PTR,
				WR_NONE, CNT_HOLD, 1'b0, ST_OK);
			5'd14: cw = uop(NXT_DONE, C_ALWAYS, STEP_DISPATCH, PTR_HOLD, RD_PTR,
				WR_NONE, CNT_DEC, 1'b0, ST_OK);
			// overwrite in place
			5'd15: cw = uop(NXT_JUMP, C_EMPTY, STEP_EMPTY, PTR_HOLD, RD_PTR,
				WR_NONE, CNT_HOLD, 1'b0, ST_OK);
			5'd16: cw = uop(NXT_JUMP, C_POS_GE_CNT, STEP_BADPOS, PTR_LOAD_POS, RD_PTR,
				WR_NONE, CNT_HOLD, 1'b0, ST_OK);
			5'd17: cw = uop(NXT_DONE, C_ALWAYS, STEP_DISPATCH, PTR_HOLD, RD_PTR,
				WR_REQ, CNT_HOLD, 1'b0, ST_OK);
			// search: scan upward from position zero
			5'd18: cw = uop(NXT_JUMP, C_EMPTY, STEP_EMPTY, PTR_ZERO, RD_PTR,
				WR_NONE, CNT_HOLD, 1'b0, ST_OK);
			5'd19: cw = uop(NXT_JUMP, C_PTR_EQ_CNT, STEP_MISS, PTR_HOLD, RD_PTR,
				WR_NONE, CNT_HOLD, 1'b0, ST_OK);
			5'd20: cw = uop(NXT_JUMP, C_KEY_MATCH, STEP_SRC_HIT, PTR_HOLD, RD_PTR,
				WR_NONE, CNT_HOLD, 1'b0, ST_OK);
			5'd21: cw = uop(NXT_JUMP, C_ALWAYS, STEP_SRC_LOOP, PTR_INC, RD_PTR,
				WR_NONE, CNT_HOLD, 1'b0, ST_OK);
			5'd22: cw = uop(NXT_DONE, C_ALWAYS, STEP_DISPATCH, PTR_HOLD, RD_PTR,
				WR_NONE, CNT_HOLD, 1'b1, ST_OK);
			// common endings
			5'd23: cw = uop(NXT_DONE, C_ALWAYS, STEP_DISPATCH, PTR_HOLD, RD_PTR,
				WR_NONE, CNT_HOLD, 1'b0, ST_NOTFOUND);
			5'd24: cw = uop(NXT_DONE, C_ALWAYS, STEP_DISPATCH, PTR_HOLD, RD_PTR,
				WR_NONE, CNT_HOLD, 1'b0, ST_FULL);
			5'd25: cw = uop(NXT_DONE, C_ALWAYS, STEP_DISPATCH, PTR_HOLD, RD_PTR,
				WR_NONE, CNT_HOLD, 1'b0, ST_EMPTY);
			5'd26: cw = uop(NXT_DONE, C_ALWAYS, STEP_DISPATCH, PTR_HOLD, RD_PTR,
				WR_NONE, CNT_HOLD, 1'b0, ST_BADPOS);
			// unknown kinds and unused steps finish with no effect
			default: cw = uop(NXT_DONE, C_ALWAYS, STEP_DISPATCH, PTR_HOLD, RD_PTR,
				WR_NONE, CNT_HOLD, 1'b0, ST_OK);
		endcase
		return cw;
	endfunction

endpackage

/* src/alist_ram.sv */
module alist_ram
	#(
		parameter int WIDTH = 8,
		parameter int DEPTH = 16,
		localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
	)
	(
		input  logic             clk,
		input  logic             we,
		input  logic [AW-1:0]    waddr,
		input  logic [WIDTH-1:0] wdata,
		input  logic [AW-1:0]    raddr,
		output logic [WIDTH-1:0] rdata
	);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* src/alist_useq.sv */
module alist_useq
	import alist_pkg::*;
	(
		input  logic              clk,
		input  logic              arst_n,
		input  logic              start,
		input  logic              hold,
		input  logic [KIND_W-1:0] kind,
		input  flags_t            flags,
		output ctl_word_t         cw,
		output logic              busy
	);

	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_next;
	logic              busy_q;
	logic              taken;

	assign cw   = microcode(step_q);
	assign busy = busy_q;

	// condition select
	always_comb begin
		unique case (cw.cond)
			C_ALWAYS:     taken = 1'b1;
			C_FULL:       taken = flags.full;
			C_EMPTY:      taken = flags.empty;
			C_POS_GT_CNT: taken = flags.pos_gt_cnt;
			C_POS_GE_CNT: taken = flags.pos_ge_cnt;
			C_PTR_EQ_POS: taken = flags.ptr_eq_pos;
			C_PTR_LAST:   taken = flags.ptr_last;
			C_PTR_EQ_CNT: taken = flags.ptr_eq_cnt;
			C_KEY_MATCH:  taken = flags.key_match;
			default:      taken = 1'b0;
		endcase
	end

	// next step
	always_comb begin
		unique case (cw.nxt)
			NXT_SEQ:  step_next = step_q + STEP_W'(1);
			NXT_JUMP: step_next = taken ? cw.target : step_q + STEP_W'(1);
			NXT_DISPATCH: begin
				unique case (kind)
					KIND_INSERT: step_next = STEP_INS;
					KIND_APPEND: step_next = STEP_APP;
					KIND_REMOVE: step_next = STEP_REM;
					KIND_MODIFY: step_next = STEP_MOD;
					KIND_SEARCH: step_next = STEP_SRC;
					default:     step_next = STEP_UNKNOWN;
				endcase
			end
			NXT_DONE: step_next = STEP_DISPATCH;
			default:  step_next = STEP_DISPATCH;
		endcase
	end

	// step counter and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_DISPATCH;
			busy_q <= 1'b0;
		end else if (!busy_q) begin
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_DISPATCH;
			end
		end else if (!hold) begin
			step_q <= step_next;
			if (cw.nxt == NXT_DONE) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

/* src/array_list_insert_remove_search.sv */
// throughput: one transaction at a time; each loop pass moves or compares one entry,
// and a result still waiting holds the next transaction at its last step
// reset: arst_n clears the list to empty and the sequencer to idle; entry memory
// contents are not cleared, only positions below the count are ever read
module array_list_insert_remove_search
	import alist_pkg::*;
	#(
		parameter int CAPACITY = CAPACITY_DEF,
		localparam int CW = $clog2(CAPACITY + 1),
		localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
	)
	(
		input  logic              clk,
		input  logic              arst_n,
		input  logic              in_valid,
		output logic              in_stall,
		input  logic [KIND_W-1:0] kind,
		input  logic [CW-1:0]     position,
		input  logic [KEY_W-1:0]  entry_key,
		input  logic [PAY_W-1:0]  entry_payload,
		output logic              out_valid,
		input  logic              out_stall,
		output logic [2:0]        status,
		output logic [AW-1:0]     found_position,
		output logic [PAY_W-1:0]  found_payload,
		output logic [CW-1:0]     entry_count
	);

	localparam int EW = KEY_W + PAY_W;

	ctl_word_t         cw;
	flags_t            flags;
	logic              busy;
	logic              accept;
	logic              hold;
	logic              advance;
	logic              finish;

	logic [KIND_W-1:0] kind_q;
	logic [CW-1:0]     pos_q;
	logic [KEY_W-1:0]  key_q;
	logic [PAY_W-1:0]  pay_q;
	logic [CW-1:0]     ptr_q;
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     cnt_next;

	logic [AW-1:0]     raddr;
	logic [EW-1:0]     rdata;
	logic [EW-1:0]     wdata;
	logic              we;

	logic              out_valid_q;
	status_t           status_q;
	logic [AW-1:0]     found_pos_q;
	logic [PAY_W-1:0]  found_pay_q;
	logic [CW-1:0]     count_q;

	assign in_stall = busy;
	assign accept   = in_valid && !busy;

	// hold the final step while the previous result is still waiting
	assign hold    = (cw.nxt == NXT_DONE) && out_valid_q && out_stall;
	assign advance = busy && !hold;
	assign finish  = advance && (cw.nxt == NXT_DONE);

	// request registers
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			pos_q  <= position;
			key_q  <= entry_key;
			pay_q  <= entry_payload;
		end
	end

	// datapath conditions
	assign flags.full       = (cnt_q == CW'(CAPACITY));
	assign flags.empty      = (cnt_q == '0);
	assign flags.pos_gt_cnt = (pos_q > cnt_q);
	assign flags.pos_ge_cnt = (pos_q >= cnt_q);
	assign flags.ptr_eq_pos = (ptr_q == pos_q);
	assign flags.ptr_last   = (({1'b0, ptr_q} + (CW + 1)'(1)) >= {1'b0, cnt_q});
	assign flags.ptr_eq_cnt = (ptr_q == cnt_q);
	assign flags.key_match  = (rdata[EW-1 -: KEY_W] == key_q);

	alist_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.hold   (hold),
		.kind   (kind_q),
		.flags  (flags),
		.cw     (cw),
		.busy   (busy)
	);

	// entry pointer
	always_ff @(posedge clk) begin
		if (advance) begin
			unique case (cw.ptr_op)
				PTR_HOLD:     ptr_q <= ptr_q;
				PTR_LOAD_CNT: ptr_q <= cnt_q;
				PTR_LOAD_POS: ptr_q <= pos_q;
				PTR_ZERO:     ptr_q <= '0;
				PTR_INC:      ptr_q <= ptr_q + CW'(1);
				PTR_DEC:      ptr_q <= ptr_q - CW'(1);
				default:      ptr_q <= ptr_q;
			endcase
		end
	end

	// entry count after the request
	always_comb begin
		unique case (cw.cnt_op)
			CNT_HOLD: cnt_next = cnt_q;
			CNT_INC:  cnt_next = cnt_q + CW'(1);
			CNT_DEC:  cnt_next = cnt_q - CW'(1);
			default:  cnt_next = cnt_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (advance) begin
			cnt_q <= cnt_next;
		end
	end

	// entry memory addressing
	always_comb begin
		unique case (cw.rd_sel)
			RD_PTR:      raddr = ptr_q[AW-1:0];
			RD_PTR_DOWN: raddr = AW'(ptr_q - CW'(1));
			RD_PTR_UP:   raddr = AW'(ptr_q + CW'(1));
			default:     raddr = ptr_q[AW-1:0];
		endcase
	end

	assign we    = advance && (cw.wr_op != WR_NONE);
	assign wdata = (cw.wr_op == WR_SHIFT) ? rdata : {key_q, pay_q};

	alist_ram #(
		.WIDTH (EW),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (ptr_q[AW-1:0]),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			status_q    <= cw.status;
			found_pos_q <= cw.capture ? ptr_q[AW-1:0] : '0;
			found_pay_q <= cw.capture ? rdata[PAY_W-1:0] : '0;
			count_q     <= cnt_next;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign found_position = found_pos_q;
	assign found_payload  = found_pay_q;
	assign entry_count    = count_q;

	// a new transaction always makes the sequencer busy
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("sequencer not busy after accepted transaction");

	// the count never passes the capacity
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	// finishing a transaction always presents a result
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> out_valid_q)
		else $error("sequencer finished without a result");

	// the count moves by at most one per step
	assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(cnt_q) |-> (cnt_q == $past(cnt_q) + CW'(1)) ||
			(cnt_q == $past(cnt_q) - CW'(1)))
		else $error("entry count jumped");

endmodule
